// ===== rtl/rtq_pkg.sv =====
// Shared types and constants of the randomized timer queue.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package rtq_pkg;

   // Default queue depth.
   localparam int RTQ_ENTRIES = 16;

   // Result status codes.
   localparam logic [1:0] STATUS_IDLE_TICK = 2'd0;
   localparam logic [1:0] STATUS_FIRED     = 2'd1;
   localparam logic [1:0] STATUS_INSERTED  = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   // Item kinds.
   localparam logic KIND_TICK   = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   // Payload of one queue entry.
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] min_ival;
      logic [15:0] max_ival;
      logic [31:0] due;
      logic [31:0] last;
   } entry_type;

   // Operation broadcast to every cell of the chain.
   typedef enum logic [1:0] {
      OP_NONE     = 2'd0,
      OP_INSERT   = 2'd1,
      OP_REINSERT = 2'd2
   } op_type;

   typedef struct packed {
      op_type    op;
      entry_type ins;
   } ctl_type;

endpackage

// ===== rtl/rtq_draw.sv =====
// Random interval draw of the timer queue: one registered multiply.
// Depends on rtq_pkg.
`timescale 1ns / 1ps

module rtq_draw (
   input  logic        clock,
   input  logic        load,
   input  logic [15:0] min_ival,
   input  logic [15:0] max_ival,
   input  logic [15:0] random_word,
   output logic [15:0] offset
);
   import rtq_pkg::*;

   logic [16:0] span;
   logic [32:0] product;
   logic [15:0] offset_ff;
   logic [15:0] offset_in;

   // The product stays below 2**32, so bits 31:16 hold the whole scaled value.
   always_comb begin
      span = {1'b0, max_ival} - {1'b0, min_ival} + 17'd1;
      product = {17'd0, random_word} * {16'd0, span};
      if (max_ival < min_ival) begin
         offset_in = 16'd0;
      end else begin
         offset_in = product[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         offset_ff <= offset_in;
      end
   end

   assign offset = offset_ff;

endmodule

// ===== rtl/rtq_cell.sv =====
// One cell of the sorted timer chain: holds one entry and its valid bit.
// Depends on rtq_pkg.
`timescale 1ns / 1ps

module rtq_cell (
   input  logic                clock,
   input  logic                reset,
   input  rtq_pkg::ctl_type    ctl,
   input  logic                left_valid,
   input  rtq_pkg::entry_type  left_entry,
   input  logic                left_le,
   input  rtq_pkg::entry_type  right_entry,
   input  logic                right_le,
   output logic                valid,
   output rtq_pkg::entry_type  entry,
   output logic                le
);
   import rtq_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;

   // A cell whose due time is not after the new one stays ahead of it.
   assign le = valid_ff && (entry_ff.due <= ctl.ins.due);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      case (ctl.op)
         OP_INSERT: begin
            if (!le) begin
               if (left_le) begin
                  valid_in = 1'b1;
                  entry_in = ctl.ins;
               end else begin
                  valid_in = left_valid;
                  entry_in = left_entry;
               end
            end
         end
         OP_REINSERT: begin
            // The front is removed, so every position looks one cell right.
            // The head always gives up the fired entry, so it takes the new one
            // even when a wrapped due time puts that one below the old front.
            if (right_le) begin
               valid_in = 1'b1;
               entry_in = right_entry;
            end else if (le || (left_le && !left_valid)) begin
               valid_in = 1'b1;
               entry_in = ctl.ins;
            end
         end
         default: begin
            valid_in = valid_ff;
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

// ===== rtl/randomized_timer_queue.sv =====
// Top level of the randomized timer queue: control, time counter, result register.
// Depends on rtq_pkg, rtq_draw and rtq_cell.
`timescale 1ns / 1ps

// The queue keeps up to ENTRIES timers in a row of cells sorted by due time,
// earliest in cell 0, with equal due times in insertion order. Every item
// goes through the transfer, in which the time counter advances for a tick,
// the front entry is checked and the interval multiply is registered, and
// then the placement, in which every cell compares its due time with the
// new one against a broadcast and shifts by one place in a single step.
// The placement waits while the result register still holds an untaken
// result, and a new request transfer is taken as soon as the placement is
// done, even if its result has not yet been taken. A tick fires at most
// one entry and reinserts it at its new due time; an insert into a full
// queue reports full status and changes nothing. Fields of a result other
// than status are zero unless the status is fired.

module randomized_timer_queue #(
   parameter int ENTRIES = rtq_pkg::RTQ_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_entry_id,
   input  logic [15:0] req_min_interval,
   input  logic [15:0] req_max_interval,
   input  logic [31:0] req_start_time,
   input  logic [15:0] req_random_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_fired_id,
   output logic [31:0] rsp_fire_time,
   output logic [31:0] rsp_previous_fire,
   output logic [31:0] rsp_next_due
);
   import rtq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_PLACE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic        req_xfer;
   logic        out_free;
   logic        place_go;
   logic [31:0] now_plus;
   logic [15:0] sel_min;
   logic [15:0] sel_max;
   logic [15:0] draw_offset;
   logic [31:0] due_new;
   ctl_type     ctl;

   logic [31:0] now_ff, now_in;
   logic        kind_ff, kind_in;
   logic [7:0]  id_ff, id_in;
   logic [15:0] min_ff, min_in;
   logic [15:0] max_ff, max_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] start_ff, start_in;
   logic        use_start_ff, use_start_in;
   logic        full_ff, full_in;
   logic        fire_ff, fire_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  fired_id_ff, fired_id_in;
   logic [31:0] fire_time_ff, fire_time_in;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] next_due_ff, next_due_in;

   logic [ENTRIES-1:0] cell_valid;
   logic [ENTRIES-1:0] cell_le;
   entry_type          cell_entry [ENTRIES];

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign place_go  = (state_ff == S_PLACE) && out_free;
   assign now_plus  = now_ff + 32'd1;

   // A tick draws with the front entry's bounds, an insert with its own.
   assign sel_min = (req_kind == KIND_INSERT) ? req_min_interval : cell_entry[0].min_ival;
   assign sel_max = (req_kind == KIND_INSERT) ? req_max_interval : cell_entry[0].max_ival;

   rtq_draw u_draw (
      .clock       (clock),
      .load        (req_xfer),
      .min_ival    (sel_min),
      .max_ival    (sel_max),
      .random_word (req_random_word),
      .offset      (draw_offset)
   );

   // Transfer cycle: capture the item and everything the placement needs.
   always_comb begin
      now_in       = now_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      base_in      = base_ff;
      start_in     = start_ff;
      use_start_in = use_start_ff;
      full_in      = full_ff;
      fire_in      = fire_ff;
      if (req_xfer) begin
         kind_in      = req_kind;
         id_in        = (req_kind == KIND_INSERT) ? req_entry_id : cell_entry[0].id;
         min_in       = sel_min;
         max_in       = sel_max;
         start_in     = req_start_time;
         full_in      = cell_valid[ENTRIES-1];
         if (req_kind == KIND_INSERT) begin
            base_in      = now_ff + {16'd0, sel_min};
            use_start_in = (req_start_time > now_ff);
            fire_in      = 1'b0;
         end else begin
            now_in       = now_plus;
            base_in      = now_plus + {16'd0, sel_min};
            use_start_in = 1'b0;
            fire_in      = cell_valid[0] && (cell_entry[0].due <= now_plus);
         end
      end
   end

   // Placement cycle: new due time and the operation broadcast to the chain.
   always_comb begin
      due_new = use_start_ff ? start_ff : (base_ff + {16'd0, draw_offset});
      ctl.ins.id       = id_ff;
      ctl.ins.min_ival = min_ff;
      ctl.ins.max_ival = max_ff;
      ctl.ins.due      = due_new;
      ctl.ins.last     = (kind_ff == KIND_INSERT) ? 32'd0 : now_ff;
      ctl.op           = OP_NONE;
      if (place_go) begin
         if (kind_ff == KIND_INSERT) begin
            ctl.op = full_ff ? OP_NONE : OP_INSERT;
         end else begin
            ctl.op = fire_ff ? OP_REINSERT : OP_NONE;
         end
      end
   end

   // Result register: loaded when the placement commits.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      fired_id_in  = fired_id_ff;
      fire_time_in = fire_time_ff;
      prev_in      = prev_ff;
      next_due_in  = next_due_ff;
      if (place_go) begin
         rsp_valid_in = 1'b1;
         fired_id_in  = 8'd0;
         fire_time_in = 32'd0;
         prev_in      = 32'd0;
         next_due_in  = 32'd0;
         if (kind_ff == KIND_INSERT) begin
            status_in = full_ff ? STATUS_FULL : STATUS_INSERTED;
         end else if (fire_ff) begin
            status_in    = STATUS_FIRED;
            fired_id_in  = id_ff;
            fire_time_in = now_ff;
            prev_in      = cell_entry[0].last;
            next_due_in  = due_new;
         end else begin
            status_in = STATUS_IDLE_TICK;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         now_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      id_ff        <= id_in;
      min_ff       <= min_in;
      max_ff       <= max_in;
      base_ff      <= base_in;
      start_ff     <= start_in;
      use_start_ff <= use_start_in;
      full_ff      <= full_in;
      fire_ff      <= fire_in;
      status_ff    <= status_in;
      fired_id_ff  <= fired_id_in;
      fire_time_ff <= fire_time_in;
      prev_ff      <= prev_in;
      next_due_ff  <= next_due_in;
   end

   // The chain: each cell sees its left and right neighbors only.
   for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic      left_valid;
      logic      left_le;
      entry_type left_entry;
      logic      right_le;
      entry_type right_entry;

      if (gi == 0) begin : g_head
         assign left_valid = 1'b0;
         assign left_le    = 1'b1;
         assign left_entry = '0;
      end else begin : g_body
         assign left_valid = cell_valid[gi-1];
         assign left_le    = cell_le[gi-1];
         assign left_entry = cell_entry[gi-1];
      end

      if (gi == ENTRIES - 1) begin : g_tail
         assign right_le    = 1'b0;
         assign right_entry = '0;
      end else begin : g_mid
         assign right_le    = cell_le[gi+1];
         assign right_entry = cell_entry[gi+1];
      end

      rtq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_valid  (left_valid),
         .left_entry  (left_entry),
         .left_le     (left_le),
         .right_entry (right_entry),
         .right_le    (right_le),
         .valid       (cell_valid[gi]),
         .entry       (cell_entry[gi]),
         .le          (cell_le[gi])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_fired_id      = fired_id_ff;
   assign rsp_fire_time     = fire_time_ff;
   assign rsp_previous_fire = prev_ff;
   assign rsp_next_due      = next_due_ff;

   // The valid cells always form a prefix of the chain.
   a_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, cell_valid} + {{ENTRIES{1'b0}}, 1'b1}))
      else $error("valid cells do not form a prefix");

   // An insert adds exactly one entry.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_INSERT) |=>
         ($countones(cell_valid) == $past($countones(cell_valid)) + 1))
      else $error("insert did not add one entry");

   // A reinsertion keeps the number of entries.
   a_reinsert_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_REINSERT) |=> $stable(cell_valid))
      else $error("reinsertion changed the number of entries");

   // A result appears only right after a placement.
   a_rsp_after_place: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(place_go))
      else $error("result without a placement");

   // Time moves only on an accepted tick.
   a_time_on_tick: assert property (@(posedge clock) disable iff (reset)
      (now_ff != $past(now_ff)) |-> $past(req_xfer && (req_kind == KIND_TICK)))
      else $error("time counter moved without a tick");

endmodule
